// File: sv/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
// Used by lkvc_lookup, lkvc_store and lru_key_value_cache_top; no dependencies.
`default_nettype none

package lkvc_pkg;

  // Storage depth and derived widths
  localparam int MAX_ENTRIES = 16;
  localparam int IDX_W       = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
  localparam int LIM_W       = IDX_W + 1;
  localparam int CAP_W       = 5;
  localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam int DATA_W      = 32;

  typedef logic [MAX_ENTRIES-1:0] entry_vec_t;
  typedef logic [IDX_W-1:0]       idx_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [LIM_W-1:0]       lim_t;
  typedef logic [CAP_W-1:0]       cap_t;
  typedef logic [CMP_W-1:0]       cmp_t;
  typedef logic [DATA_W-1:0]      data_t;

  typedef enum logic {
    OP_GET = 1'b0,
    OP_PUT = 1'b1
  } op_t;

  // Value returned by a get that misses
  localparam data_t MISS_VALUE = {DATA_W{1'b1}};
  // Capacity register after reset
  localparam cap_t  CAP_RESET  = cap_t'(16);

  // Result of the parallel tag and rank compare
  typedef struct packed {
    logic hit;
    idx_t hit_idx;
    logic free_found;
    idx_t free_idx;
    idx_t lru_idx;
  } lookup_t;

endpackage

`default_nettype wire

// File: sv/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache: request register, entry store and
// result register. Depends on lkvc_pkg and lkvc_store.
//
//   channel   signals                              direction
//   request   start, busy, op, lookup_key,         in (busy out)
//             write_value
//   result    done, hit, read_value                out
//   config    cfg_valid, cfg_ready, cfg_data       in (cfg_ready out)
//
// A request is taken on any edge with start high; busy stays low, so one
// request per cycle is sustained. Its result shows with done high for one
// cycle, after passing through the request register, where all
// entries are compared and updated at once, and then the result register.
// Synchronous reset empties the store and sets the capacity to 16.
// The receiver cannot stall results; cfg_ready is always high.
`default_nettype none

module lru_key_value_cache_top (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  logic                         op,
  input  logic signed [31:0]           lookup_key,
  input  logic signed [31:0]           write_value,
  output logic                         done,
  output logic                         hit,
  output logic signed [31:0]           read_value,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lkvc_pkg::CAP_W-1:0]   cfg_data
);

  logic            in_valid;
  lkvc_pkg::op_t   in_op;
  lkvc_pkg::data_t in_key;
  lkvc_pkg::data_t in_value;
  lkvc_pkg::cap_t  capacity;
  logic            st_hit;
  lkvc_pkg::data_t st_value;
  lkvc_pkg::data_t result_value;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;

  // Capacity register
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= lkvc_pkg::CAP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      capacity <= cfg_data;
    end
  end

  // Request register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      in_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op    <= lkvc_pkg::op_t'(op);
      in_key   <= lookup_key;
      in_value <= write_value;
    end
  end

  lkvc_store u_store (
    .clk       (clk),
    .rst       (rst),
    .go        (in_valid),
    .op        (in_op),
    .key       (in_key),
    .value     (in_value),
    .cap       (capacity),
    .hit       (st_hit),
    .hit_value (st_value)
  );

  // Form the returned word: stored value, miss marker, or zero for a put
  always_comb begin
    if (in_op == lkvc_pkg::OP_PUT) begin
      result_value = '0;
    end else if (st_hit) begin
      result_value = st_value;
    end else begin
      result_value = lkvc_pkg::MISS_VALUE;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid) begin
      hit        <= st_hit;
      read_value <= result_value;
    end
  end

endmodule

`default_nettype wire

// File: sv/lkvc_lookup.sv
// Parallel compare of the request key against every entry, plus free-slot
// and least-recent selection. Depends on lkvc_pkg.
`default_nettype none

module lkvc_lookup (
  input  lkvc_pkg::data_t      key,
  input  lkvc_pkg::entry_vec_t valid,
  input  lkvc_pkg::data_t      keys  [lkvc_pkg::MAX_ENTRIES],
  input  lkvc_pkg::idx_t       ranks [lkvc_pkg::MAX_ENTRIES],
  input  lkvc_pkg::cnt_t       count,
  output lkvc_pkg::lookup_t    res
);

  lkvc_pkg::cnt_t cnt_m1;
  lkvc_pkg::idx_t lru_rank;

  // The least recent valid entry holds rank count-1 (ranks stay a permutation)
  assign cnt_m1   = count - lkvc_pkg::cnt_t'(1);
  assign lru_rank = cnt_m1[lkvc_pkg::IDX_W-1:0];

  // Priority-encode matches, free slots and the oldest entry; lowest index wins
  always_comb begin
    res = '0;
    for (int i = lkvc_pkg::MAX_ENTRIES - 1; i >= 0; i--) begin
      if (valid[i] && (keys[i] == key)) begin
        res.hit     = 1'b1;
        res.hit_idx = lkvc_pkg::idx_t'(i);
      end
      if (!valid[i]) begin
        res.free_found = 1'b1;
        res.free_idx   = lkvc_pkg::idx_t'(i);
      end
      if (valid[i] && (ranks[i] == lru_rank)) begin
        res.lru_idx = lkvc_pkg::idx_t'(i);
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/lkvc_store.sv
// Entry storage (valid, key, value, recency rank, count) and its update for
// one request per cycle. Depends on lkvc_pkg and lkvc_lookup.
`default_nettype none

module lkvc_store (
  input  logic            clk,
  input  logic            rst,
  input  logic            go,
  input  lkvc_pkg::op_t   op,
  input  lkvc_pkg::data_t key,
  input  lkvc_pkg::data_t value,
  input  lkvc_pkg::cap_t  cap,
  output logic            hit,
  output lkvc_pkg::data_t hit_value
);

  lkvc_pkg::entry_vec_t valid;
  lkvc_pkg::data_t      keys   [lkvc_pkg::MAX_ENTRIES];
  lkvc_pkg::data_t      values [lkvc_pkg::MAX_ENTRIES];
  lkvc_pkg::idx_t       ranks  [lkvc_pkg::MAX_ENTRIES];
  lkvc_pkg::cnt_t       count;

  lkvc_pkg::lookup_t    look;
  lkvc_pkg::cmp_t       cap_ext;
  lkvc_pkg::cmp_t       eff_cap;
  logic                 take_free;
  logic                 upd;
  logic                 ins;
  lkvc_pkg::idx_t       slot;
  lkvc_pkg::lim_t       limit;
  lkvc_pkg::cnt_t       count_next;

  lkvc_lookup u_lookup (
    .key   (key),
    .valid (valid),
    .keys  (keys),
    .ranks (ranks),
    .count (count),
    .res   (look)
  );

  assign hit       = look.hit;
  assign hit_value = values[look.hit_idx];

  // Clamp the capacity register to 1..MAX_ENTRIES
  assign cap_ext = lkvc_pkg::cmp_t'(cap);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = lkvc_pkg::cmp_t'(1);
    end else if (cap_ext > lkvc_pkg::cmp_t'(lkvc_pkg::MAX_ENTRIES)) begin
      eff_cap = lkvc_pkg::cmp_t'(lkvc_pkg::MAX_ENTRIES);
    end else begin
      eff_cap = cap_ext;
    end
  end

  // Choose the slot touched by this request and the ageing limit
  always_comb begin
    ins        = go && (op == lkvc_pkg::OP_PUT) && !look.hit;
    upd        = go && (look.hit || (op == lkvc_pkg::OP_PUT));
    take_free  = (lkvc_pkg::cmp_t'(count) < eff_cap) && look.free_found;
    count_next = count;
    if (look.hit) begin
      slot  = look.hit_idx;
      limit = {1'b0, ranks[look.hit_idx]};
    end else if (take_free) begin
      slot  = look.free_idx;
      limit = lkvc_pkg::lim_t'(lkvc_pkg::MAX_ENTRIES);
      if (ins) begin
        count_next = count + lkvc_pkg::cnt_t'(1);
      end
    end else begin
      slot  = look.lru_idx;
      limit = {1'b0, ranks[look.lru_idx]};
      if (ins && (count == '0)) begin
        count_next = lkvc_pkg::cnt_t'(1);
      end
    end
  end

  // Control state: valid bits, ranks and count
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
      count <= '0;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        ranks[i] <= '0;
      end
    end else begin
      count <= count_next;
      for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
        if (upd && (slot == lkvc_pkg::idx_t'(i))) begin
          ranks[i] <= '0;
        end else if (upd && valid[i] && ({1'b0, ranks[i]} < limit)) begin
          ranks[i] <= ranks[i] + lkvc_pkg::idx_t'(1);
        end
        if (ins && (slot == lkvc_pkg::idx_t'(i))) begin
          valid[i] <= 1'b1;
        end
      end
    end
  end

  // Payload: key written on insert, value on any put
  always_ff @(posedge clk) begin
    for (int i = 0; i < lkvc_pkg::MAX_ENTRIES; i++) begin
      if (ins && (slot == lkvc_pkg::idx_t'(i))) begin
        keys[i] <= key;
      end
      if (go && (op == lkvc_pkg::OP_PUT) && (slot == lkvc_pkg::idx_t'(i))) begin
        values[i] <= value;
      end
    end
  end

endmodule

`default_nettype wire
